>>> src/wildcard_pattern_matcher_macros.svh
// Assertion macros for the checker file of the wildcard matcher.
// Every macro samples on the rising edge of clk_i and is disabled while
// rst_ni is low.
`ifndef WILDCARD_PATTERN_MATCHER_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_MACROS_SVH

// Same-cycle implication.
`define WPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/wpm_pkg.sv
// ---------------------------------------------------------------------------
// wpm_pkg
// Types and constants shared by the wildcard matcher modules.
// ---------------------------------------------------------------------------
package wpm_pkg;

  // Wildcard bytes of the pattern.
  localparam logic [7:0] STAR_CODE = 8'd42;
  localparam logic [7:0] ANY_CODE  = 8'd63;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SUBJECT = 2'd2,
    OP_FINISH  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_item_t;

  // Pattern byte held by one cell, moved toward lower cells on append.
  typedef struct packed {
    logic       valid;
    logic [7:0] code;
  } slot_t;

  // Signals a cell hands to its upper neighbor.
  typedef struct packed {
    logic valid_d;  // next-cycle occupancy of the cell
    logic step;     // a subject byte moved past this cell's byte
    logic feed;     // activates the upper neighbor's position
  } link_t;

  // Command broadcast to every cell for the accepted item.
  typedef struct packed {
    logic       consume;    // subject byte: advance the active set
    logic       start;      // recompute the active set from the pattern start
    logic       clear;      // empty the pattern
    logic       shift;      // append a byte at the top of the row
    logic [7:0] character;
  } cmd_t;

endpackage

>>> src/wpm_stream_if.sv
// ---------------------------------------------------------------------------
// wpm_stream_if
// Valid/ready channel carrying one item of payload type T.
// ---------------------------------------------------------------------------
interface wpm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/wpm_cell.sv
// ---------------------------------------------------------------------------
// wpm_cell
// One pattern position: holds a pattern byte, its occupancy and its active
// bit, and hands activation to the next position up the row.
// ---------------------------------------------------------------------------
module wpm_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wpm_pkg::cmd_t    cmd_i,
  input  wpm_pkg::slot_t   upper_slot_i,  // byte shifted in on append
  input  wpm_pkg::link_t   lower_link_i,  // from the position below
  output wpm_pkg::slot_t   slot_o,
  output wpm_pkg::link_t   link_o
);

  logic       valid_q, valid_d;
  logic [7:0] code_q, code_d;
  logic       active_q, active_d;
  logic       star_q, star_d;
  logic       hit, stay, advance, head, seed;

  // Pattern byte and occupancy: shift down on append, empty on clear.
  always_comb begin
    code_d  = cmd_i.shift ? upper_slot_i.code : code_q;
    valid_d = valid_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.shift) begin
      valid_d = upper_slot_i.valid;
    end
  end

  assign star_q = valid_q && (code_q == wpm_pkg::STAR_CODE);
  assign star_d = valid_d && (code_d == wpm_pkg::STAR_CODE);

  // A subject byte keeps an active star and advances past a matching byte.
  assign hit     = (code_q == wpm_pkg::ANY_CODE) || (code_q == cmd_i.character);
  assign stay    = active_q && star_q;
  assign advance = active_q && valid_q && !star_q && hit;

  // The lowest occupied cell is where a new subject starts.
  assign head = valid_d && !lower_link_i.valid_d;

  always_comb begin
    seed = 1'b0;
    if (cmd_i.start) begin
      seed = head;
    end else if (cmd_i.consume) begin
      seed = stay;
    end
  end

  // Stars never sit next to each other, so closure is one step deep.
  always_comb begin
    active_d = active_q;
    if (cmd_i.start || cmd_i.consume) begin
      active_d = seed || lower_link_i.feed;
    end
  end

  // A star reached by a step from below also opens the position above it.
  assign link_o.valid_d = valid_d;
  assign link_o.step    = cmd_i.consume && advance;
  assign link_o.feed    = (cmd_i.consume && advance) ||
                          ((seed || lower_link_i.step) && star_d);
  assign slot_o.valid   = valid_q;
  assign slot_o.code    = code_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      active_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      active_q <= active_d;
    end
  end

  // Pattern byte.
  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

endmodule

>>> src/wildcard_pattern_matcher.sv
// ---------------------------------------------------------------------------
// wildcard_pattern_matcher
// Whole-string matcher for patterns with '?' and '*' over a byte stream.
// ---------------------------------------------------------------------------
// Usage: items arrive on in_i, each an operation and a byte: clear the
// pattern, append a pattern byte, feed a subject byte, or finish a subject.
// Only a finish produces an item on out_o: matched and pattern_overflow.
// Items are accepted back to back at one per cycle while no result is
// stalled; the result of a finish is registered and shows on out_o the
// cycle after the finish is accepted. The rate is set by the row of
// position cells, which updates all pattern positions in parallel each
// cycle. The pattern sits right aligned in the row, its end fixed at the
// top, and runs of stars are kept as a single star, so activation moves
// only between neighbors. Bytes past MAX_PATTERN are dropped and flagged.
// Reset leaves an empty pattern and a fresh subject; there is no clearing
// pass. While a result waits on a stalled receiver, in_i is held off;
// otherwise in_i is ready every cycle.
// ---------------------------------------------------------------------------
module wildcard_pattern_matcher #(
  parameter int MAX_PATTERN = 32
) (
  input logic          clk_i,
  input logic          rst_ni,
  wpm_stream_if.sink   in_i,
  wpm_stream_if.source out_o
);

  localparam int LenW = $clog2(MAX_PATTERN + 1);

  wpm_pkg::in_item_t  in_item;
  wpm_pkg::op_e       op;
  wpm_pkg::cmd_t      cmd;
  wpm_pkg::slot_t     new_slot;
  wpm_pkg::slot_t     slot_out [MAX_PATTERN];
  wpm_pkg::link_t     link_out [MAX_PATTERN];
  wpm_pkg::out_item_t out_data_q;

  logic            accept;
  logic            room, last_star, merge_star;
  logic [LenW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;
  logic            end_active_q, end_active_d;
  logic            out_valid_q;

  assign in_item = in_i.data;
  assign op      = wpm_pkg::op_e'(in_item.operation);

  // Input is held off only while a result is stalled.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Capacity and star merging for appended bytes.
  assign room       = len_q < LenW'(MAX_PATTERN);
  assign last_star  = slot_out[MAX_PATTERN-1].valid &&
                      (slot_out[MAX_PATTERN-1].code == wpm_pkg::STAR_CODE);
  assign merge_star = last_star && (in_item.character == wpm_pkg::STAR_CODE);

  // Decode the accepted item into a command for the cell row.
  always_comb begin
    cmd           = '0;
    cmd.character = in_item.character;
    len_d         = len_q;
    ovf_d         = ovf_q;
    if (accept) begin
      case (op)
        wpm_pkg::OP_CLEAR: begin
          cmd.clear = 1'b1;
          cmd.start = 1'b1;
          len_d     = '0;
          ovf_d     = 1'b0;
        end
        wpm_pkg::OP_APPEND: begin
          cmd.start = 1'b1;
          if (room) begin
            cmd.shift = !merge_star;
            len_d     = len_q + LenW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        wpm_pkg::OP_SUBJECT: begin
          cmd.consume = 1'b1;
        end
        wpm_pkg::OP_FINISH: begin
          cmd.start = 1'b1;
        end
        default: begin
          cmd = '0;
        end
      endcase
    end
  end

  assign new_slot.valid = 1'b1;
  assign new_slot.code  = in_item.character;

  // Row of position cells; cell 0 is the lowest position.
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    wpm_pkg::slot_t upper_slot;
    wpm_pkg::link_t lower_link;

    if (i == MAX_PATTERN - 1) begin : g_top
      assign upper_slot = new_slot;
    end else begin : g_mid
      assign upper_slot = slot_out[i+1];
    end

    if (i == 0) begin : g_bottom
      assign lower_link = '0;
    end else begin : g_up
      assign lower_link = link_out[i-1];
    end

    wpm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .upper_slot_i(upper_slot),
      .lower_link_i(lower_link),
      .slot_o      (slot_out[i]),
      .link_o      (link_out[i])
    );
  end

  // End position: active means the subject so far matches the whole pattern.
  always_comb begin
    end_active_d = end_active_q;
    if (cmd.start) begin
      end_active_d = !link_out[MAX_PATTERN-1].valid_d || link_out[MAX_PATTERN-1].feed;
    end else if (cmd.consume) begin
      end_active_d = link_out[MAX_PATTERN-1].feed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= '0;
      ovf_q        <= 1'b0;
      end_active_q <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      len_q        <= len_d;
      ovf_q        <= ovf_d;
      end_active_q <= end_active_d;
      if (accept && (op == wpm_pkg::OP_FINISH)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (accept && (op == wpm_pkg::OP_FINISH)) begin
      out_data_q.matched          <= end_active_q;
      out_data_q.pattern_overflow <= ovf_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

>>> src/wpm_checker.sv
// ---------------------------------------------------------------------------
// wpm_checker
// Port-level checks of the wildcard matcher, bound to the top level.
// ---------------------------------------------------------------------------
`include "wildcard_pattern_matcher_macros.svh"

module wpm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_operation_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_matched_i,
  input logic       out_overflow_i
);

  logic in_acc;
  logic is_finish;
  logic is_clear;

  assign in_acc    = in_valid_i && in_ready_i;
  assign is_finish = in_operation_i == wpm_pkg::OP_FINISH;
  assign is_clear  = in_operation_i == wpm_pkg::OP_CLEAR;

  // A result stays offered until it is taken.
  `WPM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")

  // The input side is never held off while no result is pending.
  `WPM_ASSERT_NOW(a_in_free, !out_valid_i, in_ready_i, "input stalled with no result pending")

  // Every accepted finish yields a result in the next cycle.
  `WPM_ASSERT_NEXT(a_finish_out, in_acc && is_finish, out_valid_i, "finish gave no result")

  // Other items yield no result.
  `WPM_ASSERT_NEXT(a_no_spurious, in_acc && !is_finish && (!out_valid_i || out_ready_i), !out_valid_i, "result without finish")

  // An empty pattern matches an empty subject, without overflow.
  `WPM_ASSERT_NEXT(a_empty_match, (in_acc && is_clear) ##1 (in_acc && is_finish), out_matched_i && !out_overflow_i, "empty pattern mismatch")

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_operation_i(in_i.data.operation),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_matched_i (out_o.data.matched),
  .out_overflow_i(out_o.data.pattern_overflow)
);

>>> tb/sv/tb_wildcard_pattern_matcher.sv
// ---------------------------------------------------------------------------
// tb_wildcard_pattern_matcher
// Self-checking testbench for the whole-string wildcard matcher. A shadow
// copy of the pattern and of the set of live pattern positions predicts the
// verdict of every finish item. Each verdict on out_o is checked field by
// field against the oldest prediction. Directed tests cover the empty
// pattern, the wildcard bytes, byte zero, a star-only pattern and the full
// pattern. Random rounds then load patterns and stream subjects built to
// match or nearly match, mixed with noise, under random idling, output
// stalls and back-to-back traffic.
// ---------------------------------------------------------------------------
module tb_wildcard_pattern_matcher;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAT_CAP     = 32;
  localparam int ITEM_TARGET = 1950;
  localparam int RX_HOLD     = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_TAIL  = 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  wpm_stream_if #(.T(wpm_pkg::in_item_t))  in_if ();
  wpm_stream_if #(.T(wpm_pkg::out_item_t)) out_if ();

  wildcard_pattern_matcher #(
    .MAX_PATTERN(PAT_CAP)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Shadow state of the matcher.
  logic [7:0]       pat_mem [PAT_CAP];
  int unsigned      pat_len;
  logic [PAT_CAP:0] live_pos;
  logic             pat_ovf;

  // Verdicts predicted for finish items, oldest first.
  wpm_pkg::out_item_t verdict_q[$];

  int unsigned items_sent;
  int unsigned err_count;
  int unsigned stall_cycles;
  bit          steady;
  bit          hold_req;

  always #5 clk_i = ~clk_i;

  // Activates the position after every live star, walking upward.
  function automatic logic [PAT_CAP:0] star_closure(logic [PAT_CAP:0] s);
    for (int i = 0; i < PAT_CAP; i++) begin
      if (i < pat_len && s[i] && pat_mem[i] == wpm_pkg::STAR_CODE) begin
        s[i+1] = 1'b1;
      end
    end
    return s;
  endfunction

  // Updates the shadow state for one accepted item and predicts its verdict.
  function automatic void advance_matcher(wpm_pkg::op_e op, logic [7:0] ch);
    logic [PAT_CAP:0] nxt;
    nxt = '0;
    case (op)
      wpm_pkg::OP_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
      end
      wpm_pkg::OP_APPEND: begin
        if (pat_len < PAT_CAP) begin
          pat_mem[pat_len] = ch;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
      end
      wpm_pkg::OP_SUBJECT: begin
        for (int i = 0; i < PAT_CAP; i++) begin
          if (i < pat_len && live_pos[i]) begin
            if (pat_mem[i] == wpm_pkg::STAR_CODE) begin
              nxt[i] = 1'b1;
            end else if (pat_mem[i] == wpm_pkg::ANY_CODE || pat_mem[i] == ch) begin
              nxt[i+1] = 1'b1;
            end
          end
        end
        live_pos = star_closure(nxt);
        return;
      end
      default: begin
        verdict_q.push_back(wpm_pkg::out_item_t'{matched: live_pos[pat_len],
                                                 pattern_overflow: pat_ovf});
      end
    endcase
    // Every item but a subject byte starts a new subject.
    live_pos = star_closure((PAT_CAP+1)'(1));
  endfunction

  // Byte source biased toward wildcards, extremes and a tiny alphabet.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0:       return wpm_pkg::STAR_CODE;
      1:       return wpm_pkg::ANY_CODE;
      2:       return 8'h00;
      3:       return 8'hFF;
      4, 5:    return 8'($urandom);
      default: return 8'h61 + 8'($urandom_range(2));
    endcase
  endfunction

  // Offers one item and waits until it is accepted; valid stays high after.
  task automatic send_item(wpm_pkg::op_e op, logic [7:0] ch);
    if (!steady && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= wpm_pkg::in_item_t'{operation: op, character: ch};
    do @(posedge clk_i); while (!in_if.ready);
    advance_matcher(op, ch);
    items_sent++;
  endtask

  // Sender pauses until every predicted verdict has come back.
  task automatic wait_for_verdicts();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (verdict_q.size() != 0);
  endtask

  // One random round: usually a fresh pattern and a few subjects derived
  // from it, sometimes plain noise or a broken sequence.
  task automatic run_round();
    logic [7:0]  subj_q[$];
    int unsigned roll;
    int unsigned plen;
    int unsigned pos;
    roll = $urandom_range(99);
    if (roll < 10) begin
      repeat ($urandom_range(3, 10)) begin
        send_item(wpm_pkg::op_e'($urandom_range(3)), 8'($urandom));
      end
      return;
    end
    // Most rounds load a new pattern; the rest reuse the current one.
    if (roll >= 25) begin
      roll = $urandom_range(99);
      if (roll < 70)      plen = $urandom_range(0, 6);
      else if (roll < 90) plen = $urandom_range(7, 20);
      else                plen = $urandom_range(PAT_CAP - 4, PAT_CAP + 8);
      send_item(wpm_pkg::OP_CLEAR, 8'($urandom));
      repeat (plen) send_item(wpm_pkg::OP_APPEND, pick_char());
    end
    repeat ($urandom_range(1, 4)) begin
      // Expand the stored pattern into a subject that matches it.
      subj_q.delete();
      for (int k = 0; k < pat_len; k++) begin
        if (pat_mem[k] == wpm_pkg::STAR_CODE) begin
          repeat ($urandom_range(0, 3)) subj_q.push_back(pick_char());
        end else if (pat_mem[k] == wpm_pkg::ANY_CODE) begin
          subj_q.push_back(8'($urandom));
        end else begin
          subj_q.push_back(pat_mem[k]);
        end
      end
      // Some subjects are damaged so that they nearly match.
      if ($urandom_range(99) < 35) begin
        pos = (subj_q.size() == 0) ? 0 : $urandom_range(subj_q.size() - 1);
        case ($urandom_range(2))
          0: if (subj_q.size() != 0) subj_q[pos] = pick_char();
          1: if (subj_q.size() != 0) subj_q.delete(pos);
          default: subj_q.insert(pos, pick_char());
        endcase
      end
      foreach (subj_q[k]) send_item(wpm_pkg::OP_SUBJECT, subj_q[k]);
      // An append in the middle of a subject restarts it.
      if ($urandom_range(99) < 5) send_item(wpm_pkg::OP_APPEND, pick_char());
      send_item(wpm_pkg::OP_FINISH, 8'($urandom));
    end
  endtask

  // Empty pattern: an empty subject matches, any byte does not.
  task automatic test_empty_pattern();
    send_item(wpm_pkg::OP_FINISH, 8'hFF);
    send_item(wpm_pkg::OP_SUBJECT, 8'h61);
    send_item(wpm_pkg::OP_FINISH, 8'h00);
  endtask

  // Star, any-byte, byte zero and byte 255 in one pattern.
  task automatic test_wildcard_bytes();
    send_item(wpm_pkg::OP_CLEAR, 8'hFF);
    send_item(wpm_pkg::OP_APPEND, wpm_pkg::STAR_CODE);
    send_item(wpm_pkg::OP_APPEND, wpm_pkg::ANY_CODE);
    send_item(wpm_pkg::OP_APPEND, 8'h00);
    send_item(wpm_pkg::OP_APPEND, 8'hFF);
    send_item(wpm_pkg::OP_FINISH, 8'h00);
    send_item(wpm_pkg::OP_SUBJECT, 8'h78);
    send_item(wpm_pkg::OP_SUBJECT, 8'h79);
    send_item(wpm_pkg::OP_SUBJECT, 8'h00);
    send_item(wpm_pkg::OP_SUBJECT, 8'hFF);
    send_item(wpm_pkg::OP_FINISH, 8'hFF);
  endtask

  // A pattern made only of stars matches the empty subject.
  task automatic test_star_only();
    send_item(wpm_pkg::OP_CLEAR, 8'h00);
    send_item(wpm_pkg::OP_APPEND, wpm_pkg::STAR_CODE);
    send_item(wpm_pkg::OP_APPEND, wpm_pkg::STAR_CODE);
    send_item(wpm_pkg::OP_FINISH, 8'h00);
  endtask

  // Pattern past capacity: bytes are dropped and the flag is reported
  // until the next clear.
  task automatic test_full_pattern();
    send_item(wpm_pkg::OP_CLEAR, 8'h00);
    repeat (PAT_CAP + 2) send_item(wpm_pkg::OP_APPEND, pick_char());
    for (int k = 0; k < pat_len; k++) begin
      send_item(wpm_pkg::OP_SUBJECT,
                (pat_mem[k] == wpm_pkg::STAR_CODE) ? 8'h62 : pat_mem[k]);
    end
    send_item(wpm_pkg::OP_FINISH, 8'h00);
    send_item(wpm_pkg::OP_APPEND, 8'h61);
    send_item(wpm_pkg::OP_FINISH, 8'h00);
    send_item(wpm_pkg::OP_CLEAR, 8'h00);
    send_item(wpm_pkg::OP_FINISH, 8'h00);
  endtask

  // A long stretch with no idling on either side.
  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (20) run_round();
    steady = 1'b0;
  endtask

  // The receiver holds off while rounds keep coming, so the input stalls.
  task automatic test_output_stall();
    hold_req = 1'b1;
    repeat (12) run_round();
  endtask

  task automatic test_random_rounds();
    while (items_sent < ITEM_TARGET) run_round();
  endtask

  // Receiver: random ready, with a long hold-off on request.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk_i);
      end
      out_if.ready <= steady || ($urandom_range(99) >= 14);
    end
  end

  // Checks each accepted verdict against the oldest prediction.
  always @(posedge clk_i) begin : check_verdicts
    wpm_pkg::out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (verdict_q.size() == 0) begin
        $error("verdict with no finish pending: matched %0b, pattern_overflow %0b",
               out_if.data.matched, out_if.data.pattern_overflow);
        err_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_if.data.matched !== want.matched) begin
          $error("matched: expected %0b, got %0b", want.matched, out_if.data.matched);
          err_count++;
        end
        if (out_if.data.pattern_overflow !== want.pattern_overflow) begin
          $error("pattern_overflow: expected %0b, got %0b",
                 want.pattern_overflow, out_if.data.pattern_overflow);
          err_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    rst_ni       <= 1'b0;
    items_sent   = 0;
    err_count    = 0;
    stall_cycles = 0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    pat_len      = 0;
    pat_ovf      = 1'b0;
    live_pos     = (PAT_CAP+1)'(1);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_pattern();
    test_wildcard_bytes();
    test_star_only();
    test_full_pattern();
    wait_for_verdicts();
    test_back_to_back();
    test_output_stall();
    wait_for_verdicts();
    test_random_rounds();

    wait_for_verdicts();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $error("%0d predicted verdicts never arrived", verdict_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
